[hdl/mhpq_pkg.sv]
// ============================================================================
// mhpq_pkg: shared types and codes for the min-heap priority queue
// Holds the command and status codes and the word structs of both ports.
// ============================================================================
package mhpq_pkg;

    localparam int unsigned FIELD_KEY_W = 32;
    localparam int unsigned COUNT_W     = 11;

    // Width of a stored key; keys are kept at the full field width.
    localparam int unsigned KEY_WIDTH   = FIELD_KEY_W;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                          command;
        logic signed [FIELD_KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic signed [FIELD_KEY_W-1:0] min_key;
        logic [1:0]                    status;
        logic [COUNT_W-1:0]            count;
    } t_out_word;

endpackage

[hdl/mhpq_store.sv]
// ============================================================================
// mhpq_store: heap key memory
// One write port and one read port, both synchronous; read data is
// available in the cycle after the address is presented.
// ============================================================================
module mhpq_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

[hdl/min_heap_priority_queue.sv]
// ============================================================================
// min_heap_priority_queue: binary min-heap of signed keys
// Insert sifts the new key up; extract returns the root and sifts the last
// key down from the root, picking the smaller child (left on a tie).
// ============================================================================
// One command is taken while busy is low. An insert reads the parent and
// compares once per level climbed. An extract reads the root and the last
// entry, then reads the left child, reads the right child and compares once
// per level descended; one that empties the heap skips the descent. These
// steps come from the single read port of the key memory: each level needs
// one read (insert) or two reads (extract), and read data is registered.
// Error commands give their result word in the cycle after they are taken.
// Busy stays high through the result cycle, so the next command is taken in
// the cycle after the result at the earliest. Each command yields one result
// word on o_result, marked by o_done for a single cycle; the receiver cannot
// stall it. The key memory needs no clearing pass: only slots below the
// count are ever read.
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd,
    output logic      o_done,
    output t_out_word o_result
);

    localparam int AW = $clog2(CAPACITY);  // slot index 0..CAPACITY-1 (slot-1)
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = CW + 1;             // hole index, holds up to 2*CAPACITY+1

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_ROOT, S_DN_LAST, S_DN_LOAD,
        S_DN_RDL, S_DN_RDR, S_DN_CMP
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [HW-1:0]         r_hole;
    logic signed [KEY_WIDTH-1:0] r_moving, r_left, r_min;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [KEY_WIDTH-1:0]  wdata, rdata;

    mhpq_store #(.DEPTH(CAPACITY), .WIDTH(KEY_WIDTH), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic signed [KEY_WIDTH-1:0] rd_key;
    logic [HW-1:0] count_h, parent, lchild, rchild;
    logic          has_left, has_right, take_right;
    logic signed [KEY_WIDTH-1:0] smaller;
    logic [HW-1:0] pick;

    assign rd_key    = rdata;
    assign count_h   = HW'(r_count);
    assign parent    = r_hole >> 1;
    assign lchild    = r_hole << 1;
    assign rchild    = lchild + HW'(1);
    assign has_left  = (lchild <= count_h);
    assign has_right = (rchild <= count_h);
    // Right child wins only when it exists and is strictly smaller.
    assign take_right = has_right && (rd_key < r_left);
    assign smaller    = take_right ? rd_key : r_left;
    assign pick       = take_right ? rchild : lchild;

    function automatic logic [AW-1:0] slot(input logic [HW-1:0] h);
        logic [HW-1:0] s;
        s = h - HW'(1);
        return s[AW-1:0];
    endfunction

    function automatic t_out_word result_word(input logic signed [KEY_WIDTH-1:0] k,
                                              input t_status s,
                                              input logic [CW-1:0] c);
        t_out_word w;
        w.min_key = k;
        w.status  = s;
        w.count   = COUNT_W'(c);
        return w;
    endfunction

    // Memory port control; the read address feeds the state being entered.
    always_comb begin
        we    = 1'b0;
        waddr = slot(r_hole);
        wdata = r_moving;
        raddr = AW'(0);
        unique case (r_state)
            S_IDLE: ;
            S_UP_RD: begin
                if (r_hole == HW'(1)) begin
                    we = 1'b1;
                end else begin
                    raddr = slot(parent);
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (r_moving < rd_key) begin
                    wdata = rd_key;
                end
            end
            S_DN_ROOT: raddr = AW'(0);
            S_DN_LAST: raddr = slot(count_h + HW'(1));
            S_DN_LOAD: ;
            S_DN_RDL: begin
                if (has_left) begin
                    raddr = slot(lchild);
                end else begin
                    we = 1'b1;
                end
            end
            S_DN_RDR: raddr = has_right ? slot(rchild) : slot(lchild);
            S_DN_CMP: begin
                we = 1'b1;
                if (smaller < r_moving) begin
                    wdata = smaller;
                end
            end
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE) || o_done;

    // Sequencer, count and result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_hole   <= '0;
            r_moving <= '0;
            r_left   <= '0;
            r_min    <= '0;
            o_done   <= 1'b0;
            o_result <= '0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start && !busy) begin
                        if (i_cmd.command == CMD_INSERT) begin
                            if (r_count >= CW'(CAPACITY)) begin
                                o_result <= result_word('0, ST_FULL, r_count);
                                o_done   <= 1'b1;
                            end else begin
                                r_count  <= r_count + CW'(1);
                                r_hole   <= count_h + HW'(1);
                                r_moving <= i_cmd.key;
                                r_state  <= S_UP_RD;
                            end
                        end else if (r_count == '0) begin
                            o_result <= result_word('0, ST_EMPTY, '0);
                            o_done   <= 1'b1;
                        end else begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_DN_ROOT;
                        end
                    end
                end
                // The hole reached the root: the key was written there.
                S_UP_RD: begin
                    if (r_hole == HW'(1)) begin
                        o_result <= result_word('0, ST_OK, r_count);
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_UP_CMP;
                    end
                end
                // Parent moves down while the new key is strictly smaller.
                S_UP_CMP: begin
                    if (r_moving < rd_key) begin
                        r_hole  <= parent;
                        r_state <= S_UP_RD;
                    end else begin
                        o_result <= result_word('0, ST_OK, r_count);
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_DN_ROOT: r_state <= S_DN_LAST;
                S_DN_LAST: begin
                    r_min   <= rd_key;
                    r_state <= S_DN_LOAD;
                end
                // The last entry becomes the key that sifts down from the root.
                S_DN_LOAD: begin
                    r_moving <= rd_key;
                    r_hole   <= HW'(1);
                    if (r_count == '0) begin
                        o_result <= result_word(r_min, ST_OK, r_count);
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_DN_RDL;
                    end
                end
                S_DN_RDL: begin
                    if (has_left) begin
                        r_state <= S_DN_RDR;
                    end else begin
                        o_result <= result_word(r_min, ST_OK, r_count);
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_DN_RDR: begin
                    r_left  <= rd_key;
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (smaller < r_moving) begin
                        r_hole  <= pick;
                        r_state <= S_DN_RDL;
                    end else begin
                        o_result <= result_word(r_min, ST_OK, r_count);
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The result strobe lasts one cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done);

    // The count never exceeds the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY));

    // A command is only taken while idle.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> (r_state == S_IDLE));

    // Every result carries a defined status code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.status == ST_FULL
                    || o_result.status == ST_EMPTY));

endmodule
